>>> sv/pqs_pkg.sv
// Shared types and codes for the process queue scheduler.
`timescale 1ns / 1ps

package pqs_pkg;

    localparam int SLOT_W     = 4;
    localparam int PROC_SLOTS = 1 << SLOT_W;
    localparam int NUM_QUEUES = 3;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [1:0]        t_qid;
    typedef logic [1:0]        t_op;
    typedef logic [1:0]        t_status;

    localparam t_op OP_ADD    = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_TAKE   = 2'd2;
    localparam t_op OP_PICK   = 2'd3;

    localparam t_qid Q_READY = 2'd0;
    localparam t_qid Q_RECV  = 2'd1;
    localparam t_qid Q_SLEEP = 2'd2;
    localparam t_qid Q_NONE  = 2'd3;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_ERR   = 2'd2;

    typedef struct packed {
        t_status status;
        t_slot   slot_out;
        logic    recv_failed;
    } t_result;

endpackage

>>> sv/pqs_link_ram.sv
// Simple dual-port link memory with a registered read.
`timescale 1ns / 1ps

module pqs_link_ram #(
    parameter int DW    = 4,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pqs_seq.sv
// Command sequencer: queue registers, membership tags and link memory updates.
`timescale 1ns / 1ps

module pqs_seq
    import pqs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_op     i_opcode,
    input  t_qid    i_queue_id,
    input  t_slot   i_slot,
    input  t_slot   i_idle_slot,
    output logic    o_stall,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    typedef enum logic [2:0] {
        S_IDLE, S_POP_RD, S_POP_WB, S_PUSH_A, S_PUSH_B, S_UL_RD, S_UL_WB, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        K_TAKE, K_REMOVE, K_PICK1, K_PICK2, K_PICKR
    } t_kind;

    t_state  r_state;
    t_kind   r_kind;
    t_qid    r_q;
    t_slot   r_s;
    t_slot   r_idle_h;
    t_status r_status;
    t_slot   r_sout;
    logic    r_failed;

    t_slot   r_head     [NUM_QUEUES];
    t_slot   r_tail     [NUM_QUEUES];
    logic    r_nonempty [NUM_QUEUES];
    t_qid    r_member   [PROC_SLOTS];

    logic    nx_we, pv_we;
    t_slot   nx_waddr, nx_wdata, pv_waddr, pv_wdata;
    t_slot   rd_addr, nx_rdata, pv_rdata;
    t_slot   w_pop_slot;
    logic    w_pop_last;
    logic    w_accept;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_pop_slot = r_head[r_q];
    assign w_pop_last = (w_pop_slot == r_tail[r_q]);

    pqs_link_ram #(.DW(SLOT_W), .DEPTH(PROC_SLOTS)) u_next (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (rd_addr),
        .o_rdata (nx_rdata)
    );

    pqs_link_ram #(.DW(SLOT_W), .DEPTH(PROC_SLOTS)) u_prev (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (rd_addr),
        .o_rdata (pv_rdata)
    );

    // Link memory port control; reads and writes never share a cycle.
    always_comb begin
        nx_we    = 1'b0;
        nx_waddr = r_s;
        nx_wdata = r_s;
        pv_we    = 1'b0;
        pv_waddr = r_s;
        pv_wdata = r_s;
        rd_addr  = (r_state == S_POP_RD) ? r_head[r_q] : r_s;
        case (r_state)
            S_PUSH_A: begin
                // link old tail forward, new slot back
                nx_we    = r_nonempty[r_q];
                nx_waddr = r_tail[r_q];
                pv_we    = 1'b1;
                pv_wdata = r_nonempty[r_q] ? r_tail[r_q] : r_s;
            end
            S_PUSH_B: begin
                nx_we = 1'b1;
            end
            S_UL_WB: begin
                nx_we    = 1'b1;
                nx_waddr = pv_rdata;
                nx_wdata = (r_s == r_tail[r_q]) ? pv_rdata : nx_rdata;
                pv_we    = (r_s != r_tail[r_q]);
                pv_waddr = nx_rdata;
                pv_wdata = pv_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i]     <= '0;
                r_tail[i]     <= '0;
                r_nonempty[i] <= 1'b0;
            end
            for (int i = 0; i < PROC_SLOTS; i++) begin
                r_member[i] <= Q_NONE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_status <= ST_DONE;
                        r_sout   <= '0;
                        r_failed <= 1'b0;
                        r_q      <= i_queue_id;
                        r_s      <= i_slot;
                        if (i_opcode == OP_PICK) begin
                            r_q <= Q_READY;
                            if (!r_nonempty[Q_READY]) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_OUT;
                            end else begin
                                r_kind  <= K_PICK1;
                                r_state <= S_POP_RD;
                            end
                        end else if (i_queue_id == Q_NONE) begin
                            r_status <= ST_ERR;
                            r_state  <= S_OUT;
                        end else if (i_opcode == OP_TAKE) begin
                            if (!r_nonempty[i_queue_id]) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_OUT;
                            end else begin
                                r_kind  <= K_TAKE;
                                r_state <= S_POP_RD;
                            end
                        end else if (i_opcode == OP_ADD) begin
                            if (r_member[i_slot] != Q_NONE) begin
                                r_status <= ST_ERR;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_PUSH_A;
                            end
                        end else begin
                            if (r_member[i_slot] != i_queue_id) begin
                                r_status <= ST_ERR;
                                r_state  <= S_OUT;
                            end else if (i_slot == r_head[i_queue_id]) begin
                                r_kind  <= K_REMOVE;
                                r_state <= S_POP_RD;
                            end else begin
                                r_state <= S_UL_RD;
                            end
                        end
                    end
                end
                S_POP_RD: begin
                    r_state <= S_POP_WB;
                end
                S_POP_WB: begin
                    if (w_pop_last) begin
                        r_nonempty[r_q] <= 1'b0;
                        r_head[r_q]     <= '0;
                        r_tail[r_q]     <= '0;
                    end else begin
                        r_head[r_q] <= nx_rdata;
                    end
                    r_member[w_pop_slot] <= Q_NONE;
                    case (r_kind)
                        K_TAKE: begin
                            r_sout  <= w_pop_slot;
                            r_state <= S_OUT;
                        end
                        K_REMOVE: begin
                            r_state <= S_OUT;
                        end
                        K_PICK1: begin
                            if (w_pop_slot != i_idle_slot) begin
                                r_sout  <= w_pop_slot;
                                r_state <= S_OUT;
                            end else if (!w_pop_last) begin
                                // idle at head: take the next ready slot
                                r_idle_h <= w_pop_slot;
                                r_kind   <= K_PICK2;
                                r_state  <= S_POP_RD;
                            end else if (r_nonempty[Q_SLEEP] || !r_nonempty[Q_RECV]) begin
                                r_sout  <= w_pop_slot;
                                r_state <= S_OUT;
                            end else begin
                                r_idle_h <= w_pop_slot;
                                r_kind   <= K_PICKR;
                                r_q      <= Q_RECV;
                                r_state  <= S_POP_RD;
                            end
                        end
                        default: begin
                            // second pop of a pick: requeue idle at the ready tail
                            r_sout   <= w_pop_slot;
                            r_failed <= (r_kind == K_PICKR);
                            r_s      <= r_idle_h;
                            r_q      <= Q_READY;
                            r_state  <= S_PUSH_A;
                        end
                    endcase
                end
                S_PUSH_A: begin
                    r_state <= S_PUSH_B;
                end
                S_PUSH_B: begin
                    if (!r_nonempty[r_q]) begin
                        r_head[r_q]     <= r_s;
                        r_nonempty[r_q] <= 1'b1;
                    end
                    r_tail[r_q]   <= r_s;
                    r_member[r_s] <= r_q;
                    r_state       <= S_OUT;
                end
                S_UL_RD: begin
                    r_state <= S_UL_WB;
                end
                S_UL_WB: begin
                    if (r_s == r_tail[r_q]) begin
                        r_tail[r_q] <= pv_rdata;
                    end
                    r_member[r_s] <= Q_NONE;
                    r_state       <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall              = (r_state != S_IDLE);
    assign o_res_valid          = (r_state == S_OUT);
    assign o_res.status         = r_status;
    assign o_res.slot_out       = r_sout;
    assign o_res.recv_failed    = r_failed;

endmodule

>>> sv/process_queue_scheduler_core.sv
// Top level: configuration port, command sequencer and result register.
//
// Usage: one command beat enters on i_in_valid / o_in_stall (i_opcode,
// i_queue_id, i_slot) and yields exactly one result beat on o_out_valid /
// i_out_stall (o_status, o_slot_out, o_recv_failed). A beat moves at a
// rising edge where valid is high and stall is low.
// Each command is worked one at a time by a sequencer over the link
// memories (a read and a write port per memory, registered read): add
//   appends, remove pops or unlinks, take pops, pick pops once, or twice
//   and requeues idle; errors and empty answers go straight out.
// The result enters an output register; the next command is accepted
// as soon as the sequencer has handed its result over, even while that
// result waits on a stalled receiver. A stalled receiver holds the result
// register and, once the sequencer also has a result waiting, holds
// o_in_stall high.
// The idle slot is set through the APB register at address 0 (reset 0).
// Synchronous reset empties all three queues and clears every membership
// tag; link memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module process_queue_scheduler_core
    import pqs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_queue_id,
    input  logic [3:0]  i_slot,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot_out,
    output logic        o_recv_failed
);

    t_slot   r_idle_slot;
    logic    r_out_valid;
    t_result r_out;
    logic    res_valid;
    logic    res_ready;
    t_result res;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_slot <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_idle_slot <= pwdata[SLOT_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32-SLOT_W){1'b0}}, r_idle_slot};

    pqs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_opcode    (i_opcode),
        .i_queue_id  (i_queue_id),
        .i_slot      (i_slot),
        .i_idle_slot (r_idle_slot),
        .o_stall     (o_in_stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    // Result register: load when empty or draining, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_slot_out    = r_out.slot_out;
    assign o_recv_failed = r_out.recv_failed;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer took a second command beat back to back");

    a_no_slot_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DONE) |-> (o_slot_out == '0 && !o_recv_failed))
        else $error("error or empty result carries a slot");

    a_fail_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_recv_failed) |-> (o_status == ST_DONE))
        else $error("receive-any fail flag on a non-done result");
`endif

endmodule
